// File: design/sstt_pkg.sv
// shared constants, types and control structures of the sorted timer table
package sstt_pkg;

    localparam int SLOTS = 16;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // input transaction kinds
    localparam logic KIND_ADD     = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // result kinds
    localparam logic [1:0] RK_ADD_STATUS = 2'd0;
    localparam logic [1:0] RK_FIRED      = 2'd1;
    localparam logic [1:0] RK_DEADLINE   = 2'd2;

    // add status codes
    localparam logic ADD_OK   = 1'b0;
    localparam logic ADD_FULL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_CHECK,
        S_ADD_ACK,
        S_WALK,
        S_REINSERT,
        S_INSERT,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic latch;
        logic add_init;
        logic walk_step;
        logic walk_end;
        logic reins_load;
        logic ins_sel;
        logic ins_step;
        logic emit_ok;
        logic emit_full;
        logic emit_report;
    } cmd_t;

    typedef struct packed {
        logic             table_full;
        logic             walk_done;
        logic             cur_fires;
        logic             ins_stop;
        logic             reins_left;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } stat_t;

endpackage

// File: design/sstt_ifs.sv
// request and response channel interfaces of the sorted timer table
interface sstt_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
    logic [7:0]  handler_id;
    logic [31:0] elapsed_ms;

    modport source (output valid, output kind, output delay_ms, output period_ms,
                    output handler_id, output elapsed_ms, input ready);
    modport sink (input valid, input kind, input delay_ms, input period_ms,
                  input handler_id, input elapsed_ms, output ready);
endinterface

interface sstt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        add_status;
    logic [7:0]  fired_handler;
    logic [31:0] next_deadline_ms;
    logic        none_pending;
    logic        last;

    modport source (output valid, output result_kind, output add_status,
                    output fired_handler, output next_deadline_ms, output none_pending,
                    output last, input ready);
    modport sink (input valid, input result_kind, input add_status,
                  input fired_handler, input next_deadline_ms, input none_pending,
                  input last, output ready);
endinterface

// File: design/sstt_ctrl.sv
// controller state machine of the sorted timer table
module sstt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_kind,
    output logic           req_ready,
    input  sstt_pkg::stat_t stat,
    output sstt_pkg::cmd_t  cmd
);

    sstt_pkg::state_t state_reg;
    sstt_pkg::state_t state_next;

    // remembers whether the running transaction is an advance
    logic mode_adv_reg;
    logic mode_adv_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sstt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sstt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_kind == sstt_pkg::KIND_ADVANCE) ?
                                 sstt_pkg::S_WALK : sstt_pkg::S_ADD_CHECK;
                end
            end
            sstt_pkg::S_ADD_CHECK:
            begin
                if (!stat.table_full)
                begin
                    state_next = sstt_pkg::S_INSERT;
                end
                else if (stat.out_free)
                begin
                    state_next = sstt_pkg::S_IDLE;
                end
            end
            sstt_pkg::S_INSERT:
            begin
                if (stat.ins_stop)
                begin
                    state_next = mode_adv_reg ? sstt_pkg::S_REINSERT : sstt_pkg::S_ADD_ACK;
                end
            end
            sstt_pkg::S_ADD_ACK:
            begin
                if (stat.out_free)
                begin
                    state_next = sstt_pkg::S_IDLE;
                end
            end
            sstt_pkg::S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = sstt_pkg::S_REINSERT;
                end
            end
            sstt_pkg::S_REINSERT:
            begin
                state_next = stat.reins_left ? sstt_pkg::S_INSERT : sstt_pkg::S_REPORT;
            end
            sstt_pkg::S_REPORT:
            begin
                if (stat.out_free)
                begin
                    state_next = sstt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sstt_pkg::S_IDLE;
            end
        endcase
    end

    assign mode_adv_next = (state_reg == sstt_pkg::S_IDLE && req_valid) ?
                           (req_kind == sstt_pkg::KIND_ADVANCE) : mode_adv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_adv_reg <= 1'b0;
        end
        else
        begin
            mode_adv_reg <= mode_adv_next;
        end
    end

    // command outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            sstt_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            sstt_pkg::S_ADD_CHECK:
            begin
                if (stat.table_full)
                begin
                    cmd.emit_full = stat.out_free;
                end
                else
                begin
                    cmd.add_init = 1'b1;
                end
            end
            sstt_pkg::S_INSERT:
            begin
                cmd.ins_sel  = 1'b1;
                cmd.ins_step = 1'b1;
            end
            sstt_pkg::S_ADD_ACK:
            begin
                cmd.emit_ok = stat.out_free;
            end
            sstt_pkg::S_WALK:
            begin
                if (stat.walk_done)
                begin
                    cmd.walk_end = 1'b1;
                end
                else
                begin
                    cmd.walk_step = !stat.cur_fires || stat.out_free;
                end
            end
            sstt_pkg::S_REINSERT:
            begin
                cmd.reins_load = stat.reins_left;
            end
            sstt_pkg::S_REPORT:
            begin
                cmd.emit_report = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: design/sstt_datapath.sv
// timer table storage, walk and insert datapath, and result register
module sstt_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       in_delay_ms,
    input  logic [31:0]       in_period_ms,
    input  logic [7:0]        in_handler_id,
    input  logic [31:0]       in_elapsed_ms,
    sstt_rsp_if.source        rsp,
    input  sstt_pkg::cmd_t    cmd,
    output sstt_pkg::stat_t   stat
);

    localparam int CW = sstt_pkg::CNT_W;
    localparam int IW = sstt_pkg::IDX_W;
    localparam int N  = sstt_pkg::SLOTS;

    // table entries, kept in ascending order of remaining time
    logic [31:0] rem_reg [N];
    logic [31:0] per_reg [N];
    logic [7:0]  hid_reg [N];

    // fired periodic entries waiting for reinsertion
    logic [31:0] re_per_reg [N];
    logic [7:0]  re_hid_reg [N];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] re_n_reg, re_n_next;
    logic [CW-1:0] re_rd_reg, re_rd_next;
    logic [IW-1:0] ins_idx_reg, ins_idx_next;

    logic [31:0] elapsed_reg;
    logic [31:0] ins_rem_reg;
    logic [31:0] ins_per_reg;
    logic [7:0]  ins_hid_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg;
    logic        out_status_reg;
    logic [7:0]  out_hid_reg;
    logic [31:0] out_dl_reg;
    logic        out_none_reg;
    logic        out_last_reg;

    // shared read port: walk pointer or the slot below the insert point
    logic [IW-1:0] rd_addr;
    logic [31:0]   cur_rem;
    logic [31:0]   cur_per;
    logic [7:0]    cur_hid;
    logic          cur_fires;
    logic          ins_stop;
    logic          out_free;
    logic          fire_now;
    logic          emit_any;

    assign rd_addr = cmd.ins_sel ? IW'(ins_idx_reg - 1'b1) : rd_reg[IW-1:0];
    assign cur_rem = rem_reg[rd_addr];
    assign cur_per = per_reg[rd_addr];
    assign cur_hid = hid_reg[rd_addr];

    // saturating decrement reaches zero exactly when elapsed covers it
    assign cur_fires = (cur_rem <= elapsed_reg);
    assign ins_stop  = (ins_idx_reg == '0) || (cur_rem < ins_rem_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign fire_now  = cmd.walk_step && cur_fires;
    assign emit_any  = cmd.emit_ok || cmd.emit_full || cmd.emit_report || fire_now;

    // status to the controller
    always_comb
    begin
        stat.table_full = (count_reg == CW'(N));
        stat.walk_done  = (rd_reg == count_reg);
        stat.cur_fires  = cur_fires;
        stat.ins_stop   = ins_stop;
        stat.reins_left = (re_rd_reg != re_n_reg);
        stat.out_free   = out_free;
        stat.count      = count_reg;
    end

    // single table write port: survivor compaction or insert shift
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_rem;
    logic [31:0]   wr_per;
    logic [7:0]    wr_hid;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = kept_reg[IW-1:0];
        wr_rem  = cur_rem - elapsed_reg;
        wr_per  = cur_per;
        wr_hid  = cur_hid;
        if (cmd.walk_step && !cur_fires)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.ins_step)
        begin
            wr_en   = 1'b1;
            wr_addr = ins_idx_reg;
            if (ins_stop)
            begin
                wr_rem = ins_rem_reg;
                wr_per = ins_per_reg;
                wr_hid = ins_hid_reg;
            end
            else
            begin
                wr_rem = cur_rem;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rem_reg[wr_addr] <= wr_rem;
            per_reg[wr_addr] <= wr_per;
            hid_reg[wr_addr] <= wr_hid;
        end
    end

    // reinsert queue write
    always_ff @(posedge clk)
    begin
        if (fire_now && cur_per != '0)
        begin
            re_per_reg[re_n_reg[IW-1:0]] <= cur_per;
            re_hid_reg[re_n_reg[IW-1:0]] <= cur_hid;
        end
    end

    // pending insert operand and elapsed time
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            ins_rem_reg <= in_delay_ms;
            ins_per_reg <= in_period_ms;
            ins_hid_reg <= in_handler_id;
            elapsed_reg <= in_elapsed_ms;
        end
        else if (cmd.reins_load)
        begin
            ins_rem_reg <= re_per_reg[re_rd_reg[IW-1:0]];
            ins_per_reg <= re_per_reg[re_rd_reg[IW-1:0]];
            ins_hid_reg <= re_hid_reg[re_rd_reg[IW-1:0]];
        end
    end

    // counters and pointers
    always_comb
    begin
        count_next   = count_reg;
        rd_next      = rd_reg;
        kept_next    = kept_reg;
        re_n_next    = re_n_reg;
        re_rd_next   = re_rd_reg;
        ins_idx_next = ins_idx_reg;
        if (cmd.latch)
        begin
            rd_next    = '0;
            kept_next  = '0;
            re_n_next  = '0;
            re_rd_next = '0;
        end
        if (cmd.add_init)
        begin
            ins_idx_next = count_reg[IW-1:0];
        end
        if (cmd.walk_step)
        begin
            rd_next = CW'(rd_reg + 1'b1);
            if (!cur_fires)
            begin
                kept_next = CW'(kept_reg + 1'b1);
            end
            else if (cur_per != '0)
            begin
                re_n_next = CW'(re_n_reg + 1'b1);
            end
        end
        if (cmd.walk_end)
        begin
            count_next = kept_reg;
        end
        if (cmd.reins_load)
        begin
            ins_idx_next = count_reg[IW-1:0];
            re_rd_next   = CW'(re_rd_reg + 1'b1);
        end
        if (cmd.ins_step)
        begin
            if (ins_stop)
            begin
                count_next = CW'(count_reg + 1'b1);
            end
            else
            begin
                ins_idx_next = IW'(ins_idx_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rd_reg      <= '0;
            kept_reg    <= '0;
            re_n_reg    <= '0;
            re_rd_reg   <= '0;
            ins_idx_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            rd_reg      <= rd_next;
            kept_reg    <= kept_next;
            re_n_reg    <= re_n_next;
            re_rd_reg   <= re_rd_next;
            ins_idx_reg <= ins_idx_next;
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_any)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            out_kind_reg   <= sstt_pkg::RK_ADD_STATUS;
            out_status_reg <= sstt_pkg::ADD_OK;
            out_hid_reg    <= '0;
            out_dl_reg     <= '0;
            out_none_reg   <= 1'b0;
            out_last_reg   <= 1'b1;
            if (cmd.emit_full)
            begin
                out_status_reg <= sstt_pkg::ADD_FULL;
            end
            else if (fire_now)
            begin
                out_kind_reg <= sstt_pkg::RK_FIRED;
                out_hid_reg  <= cur_hid;
                out_last_reg <= 1'b0;
            end
            else if (cmd.emit_report)
            begin
                out_kind_reg <= sstt_pkg::RK_DEADLINE;
                out_none_reg <= (count_reg == '0);
                out_dl_reg   <= (count_reg == '0) ? 32'd0 : rem_reg[0];
            end
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.result_kind      = out_kind_reg;
    assign rsp.add_status       = out_status_reg;
    assign rsp.fired_handler    = out_hid_reg;
    assign rsp.next_deadline_ms = out_dl_reg;
    assign rsp.none_pending     = out_none_reg;
    assign rsp.last             = out_last_reg;

endmodule

// File: design/sorted_soft_timer_table_unit.sv
// Sorted software timer table, top level. Holds up to SLOTS (16) timers in ascending
// order of remaining milliseconds. Transactions are handled one at a time; the table
// has a single read port and a single write port, so every step below moves one entry.
// An add checks for room, then shifts each entry whose remaining time is not below the
// new one up by one slot, writes the new entry in the gap and reports its status; an
// add to a full table reports a full status and leaves the table unchanged.
// An advance walks the stored entries to decrement, fire and compact them, closes the
// walk, then for each fired periodic timer loads its period and inserts it the same way,
// and once no reinsert is left issues the deadline report. Results stall in the
// output register while the response side holds ready low; a new request is taken
// once the previous one has produced its last result.
module sorted_soft_timer_table_unit
(
    input  logic       clk,
    input  logic       rst_n,
    sstt_req_if.sink   req,
    sstt_rsp_if.source rsp
);

    sstt_pkg::cmd_t  cmd;
    sstt_pkg::stat_t stat;
    logic            ready_w;

    // controller
    sstt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (ready_w),
        .stat      (stat),
        .cmd       (cmd)
    );

    assign req.ready = ready_w;

    // datapath
    sstt_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_delay_ms   (req.delay_ms),
        .in_period_ms  (req.period_ms),
        .in_handler_id (req.handler_id),
        .in_elapsed_ms (req.elapsed_ms),
        .rsp           (rsp),
        .cmd           (cmd),
        .stat          (stat)
    );

    // table never holds more than its capacity
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= sstt_pkg::CNT_W'(sstt_pkg::SLOTS))
        else $error("timer table count above capacity");

    // an insert step only runs with a free slot
    a_insert_room : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_step |-> (stat.count < sstt_pkg::CNT_W'(sstt_pkg::SLOTS)))
        else $error("insert into a full timer table");

    // results only load into a free output register
    a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ok || cmd.emit_full || cmd.emit_report || (cmd.walk_step && stat.cur_fires))
        |-> stat.out_free)
        else $error("result overwrote a pending transaction");

    // a request transaction makes the block busy on the next cycle
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while previous one still running");

endmodule

// File: sim/timer_table_checker.sv
// channel monitor, timer table predictor and result comparison
`timescale 1ns / 100ps

module timer_table_checker
(
    input  logic clk,
    input  logic rst_n,
    sstt_req_if  req_mon,
    sstt_rsp_if  rsp_mon,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        add_status;
        logic [7:0]  fired_handler;
        logic [31:0] next_deadline_ms;
        logic        none_pending;
        logic        last;
    } timer_result_t;

    // predicted table contents, sorted by remaining time
    logic [31:0]   slot_rem [sstt_pkg::SLOTS];
    logic [31:0]   slot_per [sstt_pkg::SLOTS];
    logic [7:0]    slot_hid [sstt_pkg::SLOTS];
    int            live_count;
    timer_result_t expected_q [$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
        live_count = 0;
    end

    function automatic timer_result_t make_result(logic [1:0] kind, logic status,
                                                  logic [7:0] hid, logic [31:0] deadline,
                                                  logic empty, logic lst);
        timer_result_t res;
        res.result_kind      = kind;
        res.add_status       = status;
        res.fired_handler    = hid;
        res.next_deadline_ms = deadline;
        res.none_pending     = empty;
        res.last             = lst;
        return res;
    endfunction

    // append one predicted result
    function automatic void expect_result(timer_result_t res);
        expected_q = {expected_q, res};
    endfunction

    // new entry goes ahead of entries with an equal remaining time
    function automatic void insert_timer(logic [31:0] rem, logic [31:0] per, logic [7:0] hid);
        int pos;
        int i;
        pos = 0;
        while (pos < live_count && slot_rem[pos] < rem)
            pos++;
        for (i = live_count; i > pos; i--)
        begin
            slot_rem[i] = slot_rem[i - 1];
            slot_per[i] = slot_per[i - 1];
            slot_hid[i] = slot_hid[i - 1];
        end
        slot_rem[pos] = rem;
        slot_per[pos] = per;
        slot_hid[pos] = hid;
        live_count++;
    endfunction

    function automatic void predict_add(logic [31:0] delay, logic [31:0] per, logic [7:0] hid);
        if (live_count >= sstt_pkg::SLOTS)
            expect_result(make_result(sstt_pkg::RK_ADD_STATUS, sstt_pkg::ADD_FULL,
                                      8'd0, 32'd0, 1'b0, 1'b1));
        else
        begin
            insert_timer(delay, per, hid);
            expect_result(make_result(sstt_pkg::RK_ADD_STATUS, sstt_pkg::ADD_OK,
                                      8'd0, 32'd0, 1'b0, 1'b1));
        end
    endfunction

    // decrement with saturation, fire and compact, then reload periodic timers
    function automatic void predict_advance(logic [31:0] elapsed);
        logic [31:0] reload_per [sstt_pkg::SLOTS];
        logic [7:0]  reload_hid [sstt_pkg::SLOTS];
        logic [31:0] left;
        int          reload_n;
        int          kept;
        int          i;
        reload_n = 0;
        kept     = 0;
        for (i = 0; i < live_count; i++)
        begin
            left = (slot_rem[i] > elapsed) ? slot_rem[i] - elapsed : 32'd0;
            if (left == 32'd0)
            begin
                expect_result(make_result(sstt_pkg::RK_FIRED, 1'b0, slot_hid[i], 32'd0,
                                          1'b0, 1'b0));
                if (slot_per[i] != 32'd0)
                begin
                    reload_per[reload_n] = slot_per[i];
                    reload_hid[reload_n] = slot_hid[i];
                    reload_n++;
                end
            end
            else
            begin
                slot_rem[kept] = left;
                slot_per[kept] = slot_per[i];
                slot_hid[kept] = slot_hid[i];
                kept++;
            end
        end
        live_count = kept;
        for (i = 0; i < reload_n; i++)
            insert_timer(reload_per[i], reload_per[i], reload_hid[i]);
        if (live_count == 0)
            expect_result(make_result(sstt_pkg::RK_DEADLINE, 1'b0, 8'd0, 32'd0,
                                      1'b1, 1'b1));
        else
            expect_result(make_result(sstt_pkg::RK_DEADLINE, 1'b0, 8'd0, slot_rem[0],
                                      1'b0, 1'b1));
    endfunction

    function automatic void note_failure(string msg);
        if (mismatches < 10)
            $display("[%0t] %s", $realtime, msg);
        mismatches++;
    endfunction

    // watch both channels at the rising edge
    always @(posedge clk)
    begin
        timer_result_t got;
        timer_result_t want;
        if (rst_n)
        begin
            if (req_mon.valid && req_mon.ready)
            begin
                if (req_mon.kind == sstt_pkg::KIND_ADD)
                    predict_add(req_mon.delay_ms, req_mon.period_ms, req_mon.handler_id);
                else
                    predict_advance(req_mon.elapsed_ms);
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got = make_result(rsp_mon.result_kind, rsp_mon.add_status,
                                  rsp_mon.fired_handler, rsp_mon.next_deadline_ms,
                                  rsp_mon.none_pending, rsp_mon.last);
                if (expected_q.size() == 0)
                    note_failure($sformatf({"unexpected result kind=%0d st=%0d h=%0d",
                                            " dl=%0d np=%0d last=%0d"},
                                           got.result_kind, got.add_status, got.fired_handler,
                                           got.next_deadline_ms, got.none_pending, got.last));
                else
                begin
                    want = expected_q.pop_front();
                    if (got.result_kind !== want.result_kind
                        || got.add_status !== want.add_status
                        || got.fired_handler !== want.fired_handler
                        || got.next_deadline_ms !== want.next_deadline_ms
                        || got.none_pending !== want.none_pending
                        || got.last !== want.last)
                        note_failure($sformatf({"mismatch expected kind=%0d st=%0d h=%0d",
                                                " dl=%0d np=%0d last=%0d",
                                                " got kind=%0d st=%0d h=%0d",
                                                " dl=%0d np=%0d last=%0d"},
                                               want.result_kind, want.add_status,
                                               want.fired_handler, want.next_deadline_ms,
                                               want.none_pending, want.last,
                                               got.result_kind, got.add_status,
                                               got.fired_handler, got.next_deadline_ms,
                                               got.none_pending, got.last));
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// File: sim/testbench.sv
// testbench top: clock, reset, stimulus, response backpressure and verdict
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 300;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic calm      = 1'b0;
    logic rsp_ready = 1'b0;
    int   stall_left = 0;
    int   mismatches;
    int   pending;

    sstt_req_if req ();
    sstt_rsp_if rsp ();

    assign rsp.ready = rsp_ready;

    sorted_soft_timer_table_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    timer_table_checker table_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req),
        .rsp_mon    (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        else if (r < 80)
            return $urandom_range(1, 60);
        else if (r < 95)
            return $urandom;
        else
            return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 32'd0;
        else if (r < 85)
            return $urandom_range(1, 60);
        else if (r < 95)
            return $urandom;
        else
            return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        else if (r < 85)
            return $urandom_range(1, 40);
        else if (r < 95)
            return $urandom;
        else
            return 32'hFFFF_FFFF;
    endfunction

    // response-side stalls
    always @(negedge clk)
    begin
        int   r;
        logic nxt;
        r = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left--;
            nxt = 1'b0;
        end
        else if (calm || r < 75)
            nxt = 1'b1;
        else
        begin
            nxt = 1'b0;
            stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
        rsp_ready <= nxt;
    end

    // one request transaction, fields that the kind ignores carry noise
    task automatic send_item(logic kind, logic [31:0] delay, logic [31:0] per,
                             logic [7:0] hid, logic [31:0] elapsed);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        repeat (gap)
        begin
            req.valid      = 1'b0;
            req.kind       = 1'($urandom_range(0, 1));
            req.delay_ms   = $urandom;
            req.period_ms  = $urandom;
            req.handler_id = 8'($urandom_range(0, 255));
            req.elapsed_ms = $urandom;
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.kind  = kind;
        if (kind == sstt_pkg::KIND_ADD)
        begin
            req.delay_ms   = delay;
            req.period_ms  = per;
            req.handler_id = hid;
            req.elapsed_ms = $urandom;
        end
        else
        begin
            req.delay_ms   = $urandom;
            req.period_ms  = $urandom;
            req.handler_id = 8'($urandom_range(0, 255));
            req.elapsed_ms = elapsed;
        end
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic add_timer(logic [31:0] delay, logic [31:0] per, logic [7:0] hid);
        send_item(sstt_pkg::KIND_ADD, delay, per, hid, 32'd0);
    endtask

    task automatic advance_time(logic [31:0] elapsed);
        send_item(sstt_pkg::KIND_ADVANCE, 32'd0, 32'd0, 8'd0, elapsed);
    endtask

    // hold the request side until every expected result is back
    task automatic wait_drained();
        @(negedge clk);
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int n;
        int r;
        int i;
        int burst_left;
        burst_left     = 0;
        req.valid      = 1'b0;
        req.kind       = sstt_pkg::KIND_ADD;
        req.delay_ms   = 32'd0;
        req.period_ms  = 32'd0;
        req.handler_id = 8'd0;
        req.elapsed_ms = 32'd0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // advances on an empty table
        advance_time(32'd0);
        advance_time(32'hFFFF_FFFF);
        // zero delay fires even with nothing elapsed
        add_timer(32'd0, 32'd0, 8'd0);
        advance_time(32'd0);
        // equal delays, one-shot and periodic, reload without refiring
        add_timer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        add_timer(32'd5, 32'd3, 8'd1);
        add_timer(32'd5, 32'd0, 8'd2);
        advance_time(32'd5);
        // fill the table, overflow it, then fire everything
        for (i = 0; i < 14; i++)
            add_timer(32'(i * 7), (i % 3 == 0) ? 32'd0 : 32'(i + 1), 8'(16 + i));
        add_timer(32'd1, 32'd1, 8'hAA);
        advance_time(32'hFFFF_FFFF);

        // random traffic with bursts of adds that overflow the table
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = ((n % 100) >= 40) && ((n % 100) < 60);
            if (n == 150 || n == 300)
                wait_drained();
            if (burst_left > 0)
            begin
                burst_left--;
                add_timer(pick_delay(), pick_period(), 8'($urandom_range(0, 255)));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    burst_left = $urandom_range(8, 18);
                if (r < 50)
                    add_timer(pick_delay(), pick_period(), 8'($urandom_range(0, 255)));
                else
                    advance_time(pick_elapsed());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
design/sstt_pkg.sv
design/sstt_ifs.sv
design/sstt_ctrl.sv
design/sstt_datapath.sv
design/sorted_soft_timer_table_unit.sv
sim/timer_table_checker.sv
sim/testbench.sv
